>>> rtl/core/wtsd_pkg.sv
`timescale 1ns / 1ps
// Package for the weighted tardiness subset DP block.
// Field widths, cost constants and the controller/datapath command and status structs.
package wtsd_pkg;

  localparam int TIME_W   = 8;
  localparam int WEIGHT_W = 8;
  localparam int DUE_W    = 16;
  localparam int COST_W   = 32;

  localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

  typedef struct packed {
    logic load_job;
    logic start;
    logic acc_total;
    logic best_init;
    logic k_step;
    logic rd_issue;
    logic mul_en;
    logic acc_best;
    logic wr_cost;
    logic set_step;
    logic out_load;
  } wtsd_cmd_t;

  typedef struct packed {
    logic k_last;
    logic k_member;
    logic set_last;
    logic out_busy;
  } wtsd_sts_t;

endpackage

>>> rtl/core/wtsd_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the subset DP: job load, per-set time sum, per-member update, result hand-off.
// Depends on wtsd_pkg.
module wtsd_ctrl
  import wtsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last_job,
  output logic      in_ready,
  input  wtsd_sts_t sts,
  output wtsd_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_LOAD = 8'b0000_0001,
    S_INIT = 8'b0000_0010,
    S_SUM  = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_ACC  = 8'b0010_0000,
    S_WR   = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_job = 1'b1;
          if (in_last_job) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.start = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.acc_total = 1'b1;
        cmd.k_step    = 1'b1;
        if (sts.k_last) begin
          cmd.best_init = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_RD: begin
        if (sts.k_member) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_MUL;
        end else begin
          cmd.k_step = 1'b1;
          if (sts.k_last) begin
            state_nxt = S_WR;
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_best = 1'b1;
        cmd.k_step   = 1'b1;
        state_nxt    = sts.k_last ? S_WR : S_RD;
      end
      S_WR: begin
        cmd.wr_cost = 1'b1;
        if (sts.set_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.set_step = 1'b1;
          state_nxt    = S_SUM;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

>>> rtl/core/wtsd_dpath.sv
`timescale 1ns / 1ps
// Datapath for the subset DP: job store, subset cost memory, tardiness multiply,
// saturating add and running minimum, result register. Depends on wtsd_pkg.
module wtsd_dpath
  import wtsd_pkg::*;
#(
  parameter int MAX_JOBS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wtsd_cmd_t           cmd,
  output wtsd_sts_t           sts,
  input  logic [TIME_W-1:0]   in_proc_time,
  input  logic [WEIGHT_W-1:0] in_job_weight,
  input  logic [DUE_W-1:0]    in_due_time,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COST_W-1:0]   out_min_cost,
  output logic                out_overflowed
);

  localparam int KW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW    = $clog2(MAX_JOBS + 1);
  localparam int SW    = MAX_JOBS;
  localparam int DEPTH = 1 << MAX_JOBS;
  localparam int TW    = $clog2(MAX_JOBS * ((1 << TIME_W) - 1) + 1);
  localparam int CMPW  = ((TW > DUE_W) ? TW : DUE_W) + 1;
  localparam int PW    = WEIGHT_W + TW;

  logic [TIME_W-1:0]   time_r   [MAX_JOBS];
  logic [WEIGHT_W-1:0] weight_r [MAX_JOBS];
  logic [DUE_W-1:0]    due_r    [MAX_JOBS];
  logic [COST_W-1:0]   cost_mem [DEPTH];

  logic [CW-1:0]     count_r;
  logic [KW-1:0]     k_r;
  logic [SW-1:0]     set_r;
  logic [TW-1:0]     total_r;
  logic [COST_W-1:0] best_r;
  logic [COST_W-1:0] rd_data_r;
  logic [TW-1:0]     late_r;
  logic [PW-1:0]     prod_r;
  logic              sat_r;
  logic              out_valid_r;
  logic [COST_W-1:0] out_cost_r;
  logic              out_ovf_r;

  logic [SW-1:0]     full_mask;
  logic [SW-1:0]     rd_addr;
  logic              wr_en;
  logic [SW-1:0]     wr_addr;
  logic [COST_W-1:0] wr_data;
  logic [CMPW-1:0]   diff;
  logic [TW-1:0]     late;
  logic [COST_W:0]   sum;
  logic [COST_W-1:0] cand;

  always_comb begin
    for (int i = 0; i < SW; i++) begin
      full_mask[i] = (CW'(i) < count_r);
    end
  end

  assign sts.k_last   = (CW'(k_r) == (count_r - CW'(1)));
  assign sts.k_member = set_r[k_r];
  assign sts.set_last = (set_r == full_mask);
  assign sts.out_busy = out_valid_r && !out_ready;

  assign rd_addr = set_r & ~(SW'(1) << k_r);
  assign wr_en   = cmd.start || cmd.wr_cost;
  assign wr_addr = cmd.start ? '0 : set_r;
  assign wr_data = cmd.start ? '0 : best_r;

  assign diff = CMPW'(total_r) - CMPW'(due_r[k_r]);
  assign late = diff[CMPW-1] ? '0 : TW'(diff);

  assign sum  = {1'b0, rd_data_r} + (COST_W + 1)'(prod_r);
  assign cand = sum[COST_W] ? COST_INF : sum[COST_W-1:0];

  // job store
  always_ff @(posedge clk) begin
    if (cmd.load_job && (count_r < CW'(MAX_JOBS))) begin
      time_r[count_r[KW-1:0]]   <= in_proc_time;
      weight_r[count_r[KW-1:0]] <= in_job_weight;
      due_r[count_r[KW-1:0]]    <= in_due_time;
    end
  end

  // subset cost memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cost_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data_r <= cost_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      late_r <= late;
    end
    if (cmd.mul_en) begin
      prod_r <= PW'(weight_r[k_r]) * PW'(late_r);
    end
    if (cmd.start || cmd.set_step) begin
      total_r <= '0;
    end else if (cmd.acc_total && set_r[k_r]) begin
      total_r <= total_r + TW'(time_r[k_r]);
    end
    if (cmd.best_init) begin
      best_r <= COST_INF;
    end else if (cmd.acc_best && (cand < best_r)) begin
      best_r <= cand;
    end
    if (cmd.start) begin
      set_r <= SW'(1);
    end else if (cmd.set_step) begin
      set_r <= set_r + SW'(1);
    end
    if (cmd.start) begin
      k_r <= '0;
    end else if (cmd.k_step) begin
      k_r <= sts.k_last ? '0 : k_r + KW'(1);
    end
    if (cmd.out_load) begin
      out_cost_r <= best_r;
      out_ovf_r  <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        count_r <= '0;
      end else if (cmd.load_job && (count_r < CW'(MAX_JOBS))) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.start) begin
        sat_r <= 1'b0;
      end else if (cmd.acc_best && sum[COST_W]) begin
        sat_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_min_cost   = out_cost_r;
  assign out_overflowed = out_ovf_r;

endmodule

>>> rtl/core/weighted_tardiness_subset_dp.sv
`timescale 1ns / 1ps
// Top level of the single-machine total weighted tardiness solver (subset DP).
// Instantiates wtsd_ctrl and wtsd_dpath; depends on wtsd_pkg.
//
// Jobs stream in one beat each; the beat with in_last_job set also loads its job and
// starts the solve over all jobs held (at most MAX_JOBS; extra jobs are dropped). One
// result beat follows: the minimum total weighted tardiness, saturated to 32 bits, and
// a flag if any sum saturated. The solve walks every subset in order through a
// 2^MAX_JOBS x 32 cost memory with one read and one write port: per subset, it sums
// the processing times of its members, then for each member does a memory read, a
// multiply, and an add and minimum, skips each non-member, and writes the result back.
// The input is held off during the solve; the result sits in an output register so
// loading of the next job set can proceed while it waits to be taken. No clearing
// pass is needed after reset.
module weighted_tardiness_subset_dp
  import wtsd_pkg::*;
#(
  parameter int MAX_JOBS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TIME_W-1:0]   in_proc_time,
  input  logic [WEIGHT_W-1:0] in_job_weight,
  input  logic [DUE_W-1:0]    in_due_time,
  input  logic                in_last_job,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COST_W-1:0]   out_min_cost,
  output logic                out_overflowed
);

  wtsd_cmd_t cmd;
  wtsd_sts_t sts;

  wtsd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last_job (in_last_job),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  wtsd_dpath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_proc_time   (in_proc_time),
    .in_job_weight  (in_job_weight),
    .in_due_time    (in_due_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_min_cost   (out_min_cost),
    .out_overflowed (out_overflowed)
  );

endmodule

>>> rtl/core/wtsd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for weighted_tardiness_subset_dp, bound to the top level.
// Depends on wtsd_pkg.
module wtsd_checker
  import wtsd_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_last_job,
  input logic                out_valid,
  input logic                out_ready,
  input logic [COST_W-1:0]   out_min_cost,
  input logic                out_overflowed
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_min_cost) && $stable(out_overflowed))
    else $error("result beat changed while stalled");

  // input closes once the final job is taken
  a_solve_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_job |=> !in_ready)
    else $error("input open after final job");

  // ordinary job beats keep the input open
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_job |=> in_ready)
    else $error("input closed after ordinary job");

  // a result appears exactly as the solve ends and input reopens
  a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready && $past(!in_ready))
    else $error("result beat outside end of solve");

endmodule

bind weighted_tardiness_subset_dp wtsd_checker u_wtsd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_last_job    (in_last_job),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_min_cost   (out_min_cost),
  .out_overflowed (out_overflowed)
);
